FILE: rtl/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is high
`define XBT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked implication, off while reset is high
`define XBT_ASSERT_IMP(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`endif

FILE: rtl/xbt_pkg.sv
package xbt_pkg;

  localparam int VALUE_BITS    = 32;
  localparam int NODE_CAPACITY = 4096;
  localparam int COUNT_BITS    = 20;
  localparam int NODE_W        = $clog2(NODE_CAPACITY);
  localparam int FREE_W        = NODE_W + 1;
  localparam int LVL_W         = $clog2(VALUE_BITS);
  localparam int OP_W          = 3;
  localparam int IN_W          = 56;
  localparam int OUT_W         = 56;

  typedef logic [NODE_W-1:0]     node_t;
  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [VALUE_BITS-1:0] value_t;

  typedef struct packed {
    node_t l1;
    node_t l0;
    cnt_t  cnt;
  } rec_t;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 3'd0,
    OP_ERASE   = 3'd1,
    OP_COUNT   = 3'd2,
    OP_XOR_ALL = 3'd3,
    OP_KTH     = 3'd4,
    OP_MIN_XOR = 3'd5,
    OP_MAX_XOR = 3'd6,
    OP_SIZE    = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_FIND,
    S_FIND_W,
    S_REWIND,
    S_MOD,
    S_MOD_W,
    S_LEAF,
    S_SEL,
    S_SEL_W,
    S_SEL_R,
    S_DONE
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_CHECK,
    CMD_RD_P,
    CMD_FIND_MISS,
    CMD_FOLLOW,
    CMD_REWIND,
    CMD_MOD,
    CMD_MOD_NEXT,
    CMD_LEAF,
    CMD_DECIDE,
    CMD_SEL_NEXT,
    CMD_PUSH
  } cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    early;
    logic    plink_zero;
    logic    lvl_zero;
    logic    pool_short;
    logic    rd_cnt_zero;
    logic    take;
    logic    nlink_zero;
    logic    out_free;
  } dp_status_t;

  function automatic node_t link_of(rec_t r, logic b);
    return b ? r.l1 : r.l0;
  endfunction

endpackage

FILE: rtl/xbt_ctrl.sv
`include "assert_macros.svh"

module xbt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  xbt_pkg::dp_status_t st,
  output xbt_pkg::cmd_t       cmd
);
  import xbt_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (st.early) begin
          state_next = S_DONE;
        end else if (st.op == OP_KTH || st.op == OP_MIN_XOR || st.op == OP_MAX_XOR) begin
          state_next = S_SEL;
        end else begin
          state_next = S_FIND;
        end
      end
      S_FIND: begin
        if (!st.plink_zero) begin
          state_next = S_FIND_W;
        end else if (st.op == OP_INSERT && !st.pool_short) begin
          state_next = S_REWIND;
        end else begin
          state_next = S_DONE;
        end
      end
      S_FIND_W: begin
        if (!st.lvl_zero) begin
          state_next = S_FIND;
        end else if (st.op == OP_INSERT) begin
          state_next = S_REWIND;
        end else if (st.op == OP_ERASE && !st.rd_cnt_zero) begin
          state_next = S_REWIND;
        end else begin
          state_next = S_DONE;
        end
      end
      S_REWIND: state_next = S_MOD;
      S_MOD:    state_next = S_MOD_W;
      S_MOD_W: begin
        state_next = st.lvl_zero ? S_LEAF : S_MOD;
      end
      S_LEAF: state_next = S_DONE;
      S_SEL:  state_next = S_SEL_W;
      S_SEL_W: begin
        if (st.nlink_zero) begin
          state_next = S_DONE;
        end else if (st.take) begin
          state_next = st.lvl_zero ? S_DONE : S_SEL;
        end else begin
          state_next = S_SEL_R;
        end
      end
      S_SEL_R: begin
        state_next = st.lvl_zero ? S_DONE : S_SEL;
      end
      S_DONE: begin
        if (st.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = CMD_NONE;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd = CMD_LOAD;
      end
      S_CHECK:  cmd = CMD_CHECK;
      S_FIND:   cmd = st.plink_zero ? CMD_FIND_MISS : CMD_RD_P;
      S_FIND_W: cmd = CMD_FOLLOW;
      S_REWIND: cmd = CMD_REWIND;
      S_MOD:    cmd = CMD_MOD;
      S_MOD_W:  cmd = CMD_MOD_NEXT;
      S_LEAF:   cmd = CMD_LEAF;
      S_SEL:    cmd = CMD_RD_P;
      S_SEL_W:  cmd = CMD_DECIDE;
      S_SEL_R:  cmd = CMD_SEL_NEXT;
      S_DONE: begin
        if (st.out_free) cmd = CMD_PUSH;
      end
      default: cmd = CMD_NONE;
    endcase
  end

  `XBT_ASSERT_IMP(a_push_free, clk, rst, cmd == CMD_PUSH, st.out_free, "push into full output")

endmodule

FILE: rtl/xbt_dp.sv
`include "assert_macros.svh"

module xbt_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  xbt_pkg::cmd_t               cmd,
  output xbt_pkg::dp_status_t         st,
  input  logic [xbt_pkg::OP_W-1:0]    in_opcode,
  input  xbt_pkg::value_t             in_value,
  input  xbt_pkg::cnt_t               in_rank,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [xbt_pkg::OUT_W-1:0]   m_tdata
);
  import xbt_pkg::*;

  localparam int SUM_W = FREE_W + 1;

  rec_t    mem [NODE_CAPACITY];
  rec_t    rdata;

  opcode_t op;
  value_t  x;
  value_t  key;
  value_t  mask;
  value_t  ret;
  cnt_t    k;
  logic [LVL_W-1:0] lvl;
  node_t   v;
  rec_t    cur;
  rec_t    root;
  logic    fresh;
  logic [FREE_W-1:0] free;
  status_t res_status;
  cnt_t    res_count;
  status_t out_status;
  value_t  out_value;
  cnt_t    out_count;

  logic    is_max;
  logic    pbit;
  node_t   plink;
  cnt_t    cnt_eff;
  logic    take;
  logic    dir;
  node_t   nlink;
  logic    alloc;
  node_t   nnode;
  logic    pool_short;
  logic    early;
  logic    out_free;
  rec_t    wrec;
  rec_t    lrec;
  logic    we;
  logic    re;
  node_t   raddr;
  value_t  res_value;
  cnt_t    cnt_step;

  assign is_max   = (op == OP_MAX_XOR);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    case (op)
      OP_KTH:     pbit = mask[lvl];
      OP_MIN_XOR: pbit = x[lvl] ^ mask[lvl];
      OP_MAX_XOR: pbit = x[lvl] ^ is_max ^ mask[lvl];
      default:    pbit = key[lvl];
    endcase
  end

  assign plink   = link_of(cur, pbit);
  assign cnt_eff = (plink == '0) ? '0 : rdata.cnt;
  assign take    = (op == OP_KTH) ? (k < cnt_eff) : (cnt_eff != '0);
  assign dir     = take ? pbit : ~pbit;
  assign nlink   = link_of(cur, dir);
  assign alloc   = (op == OP_INSERT) && (plink == '0);
  assign nnode   = alloc ? free[NODE_W-1:0] : plink;

  assign pool_short = ({1'b0, free} + SUM_W'(lvl) + SUM_W'(1)) > SUM_W'(NODE_CAPACITY);

  always_comb begin
    case (op)
      OP_INSERT:  early = (root.cnt == '1);
      OP_XOR_ALL: early = 1'b1;
      OP_KTH:     early = (k >= root.cnt);
      OP_MIN_XOR: early = (root.cnt == '0);
      OP_MAX_XOR: early = (root.cnt == '0);
      OP_SIZE:    early = 1'b1;
      default:    early = 1'b0;
    endcase
  end

  assign cnt_step = (op == OP_INSERT) ? cnt_t'(1) : '1;

  always_comb begin
    wrec     = cur;
    wrec.cnt = cur.cnt + cnt_step;
    if (pbit) begin
      wrec.l1 = nnode;
    end else begin
      wrec.l0 = nnode;
    end
    lrec     = cur;
    lrec.cnt = cur.cnt + cnt_step;
  end

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    raddr = plink;
    case (cmd)
      CMD_RD_P: re = 1'b1;
      CMD_MOD: begin
        we    = (v != '0);
        re    = !alloc;
        raddr = nnode;
      end
      CMD_LEAF: we = 1'b1;
      CMD_DECIDE: begin
        re    = !take && (nlink != '0);
        raddr = nlink;
      end
      default: re = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[v] <= (cmd == CMD_LEAF) ? lrec : wrec;
    if (re) rdata <= mem[raddr];
  end

  always_comb begin
    if (res_status != ST_OK) begin
      res_value = '0;
    end else if (op == OP_KTH) begin
      res_value = ret;
    end else if (op == OP_MIN_XOR || op == OP_MAX_XOR) begin
      res_value = x ^ ret;
    end else begin
      res_value = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask     <= '0;
      free     <= FREE_W'(1);
      root     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd == CMD_PUSH) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (cmd)
        CMD_LOAD: begin
          op         <= opcode_t'(in_opcode);
          x          <= in_value;
          key        <= in_value ^ mask;
          k          <= in_rank;
          ret        <= '0;
          res_status <= ST_OK;
          res_count  <= '0;
        end
        CMD_CHECK: begin
          v   <= '0;
          cur <= root;
          lvl <= LVL_W'(VALUE_BITS - 1);
          case (op)
            OP_INSERT:  if (early) res_status <= ST_FULL;
            OP_XOR_ALL: mask <= mask ^ x;
            OP_KTH:     if (early) res_status <= ST_EMPTY;
            OP_MIN_XOR: if (early) res_status <= ST_EMPTY;
            OP_MAX_XOR: if (early) res_status <= ST_EMPTY;
            OP_SIZE:    res_count <= root.cnt;
            default:    res_count <= '0;
          endcase
        end
        CMD_FIND_MISS: begin
          if (op == OP_ERASE) begin
            res_status <= ST_NOT_FOUND;
          end else if (op == OP_INSERT && pool_short) begin
            res_status <= ST_FULL;
          end
        end
        CMD_FOLLOW: begin
          cur <= rdata;
          v   <= plink;
          if (lvl != '0) begin
            lvl <= lvl - 1'b1;
          end else if (op == OP_COUNT) begin
            res_count <= rdata.cnt;
          end else if (op == OP_ERASE && rdata.cnt == '0) begin
            res_status <= ST_NOT_FOUND;
          end
        end
        CMD_REWIND: begin
          v   <= '0;
          cur <= root;
          lvl <= LVL_W'(VALUE_BITS - 1);
        end
        CMD_MOD: begin
          if (v == '0) root <= wrec;
          if (alloc) free <= free + 1'b1;
          fresh <= alloc;
          v     <= nnode;
        end
        CMD_MOD_NEXT: begin
          cur <= fresh ? '0 : rdata;
          if (lvl != '0) lvl <= lvl - 1'b1;
        end
        CMD_DECIDE: begin
          ret[lvl] <= (op == OP_KTH) ? ~take : (dir ^ mask[lvl]);
          if (op == OP_KTH && !take) k <= k - cnt_eff;
          v <= nlink;
          if (take) begin
            cur <= rdata;
            if (lvl != '0) lvl <= lvl - 1'b1;
          end
        end
        CMD_SEL_NEXT: begin
          cur <= rdata;
          if (lvl != '0) lvl <= lvl - 1'b1;
        end
        CMD_PUSH: begin
          out_status <= res_status;
          out_value  <= res_value;
          out_count  <= res_count;
        end
        default: begin
          fresh <= fresh;
        end
      endcase
    end
  end

  // status, result_value, result_count, zero fill
  assign m_tdata = {2'b00, out_count, out_value, out_status};

  assign st.op          = op;
  assign st.early       = early;
  assign st.plink_zero  = (plink == '0);
  assign st.lvl_zero    = (lvl == '0);
  assign st.pool_short  = pool_short;
  assign st.rd_cnt_zero = (rdata.cnt == '0);
  assign st.take        = take;
  assign st.nlink_zero  = (nlink == '0);
  assign st.out_free    = out_free;

  `XBT_ASSERT(a_free_cap, clk, rst, free <= FREE_W'(NODE_CAPACITY), "node pool pointer past capacity")
  `XBT_ASSERT_IMP(a_wr_addr, clk, rst, we, (v != '0) && ({1'b0, v} < free), "write to unallocated node")
  `XBT_ASSERT_IMP(a_alloc_room, clk, rst, (cmd == CMD_MOD) && alloc, free < FREE_W'(NODE_CAPACITY), "allocation with empty pool")

endmodule

FILE: rtl/xor_binary_trie_multiset_core.sv
// One request is handled at a time; s_tready is high only while the core is idle.
// Xor all and size need no trie walk; insert and erase first find the key, then update the path.
// Each trie level visited costs one registered node memory read, and a second read when kth
// or min/max turns away from the preferred child.
// Reset: synchronous; root node, pool pointer and xor mask are registers and take their reset
// values at once, so no clearing pass runs and a request is taken straight out of reset.
module xor_binary_trie_multiset_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [xbt_pkg::IN_W-1:0]  s_tdata,  // opcode, value, rank, zero fill
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [xbt_pkg::OUT_W-1:0] m_tdata   // status, result_value, result_count, zero fill
);
  import xbt_pkg::*;

  cmd_t       cmd;
  dp_status_t st;

  xbt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  xbt_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .in_opcode (s_tdata[OP_W-1:0]),
    .in_value  (s_tdata[OP_W +: VALUE_BITS]),
    .in_rank   (s_tdata[OP_W + VALUE_BITS +: COUNT_BITS]),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
